@@ sv/shell_command_line_tokenizer_defines.svh @@
// assertion macros shared by the tokenizer rtl
`ifndef SHELL_COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define SCLT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCLT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sclt_pkg.sv @@
package sclt_pkg;

    localparam int FD_BITS  = 10;
    localparam int MAX_RES  = 3;
    localparam int CNT_BITS = $clog2(MAX_RES + 1);

    localparam int OUT_FIELD_W = 8 + 2 * FD_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [FD_BITS-1:0] FD_MAX     = '1;
    localparam logic [FD_BITS-1:0] FD_DEF_IN  = '0;
    localparam logic [FD_BITS-1:0] FD_DEF_OUT = FD_BITS'(1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_BAR    = 8'h7c;

    localparam logic [2:0] KIND_IN_DUP    = 3'd0;
    localparam logic [2:0] KIND_IN_FILE   = 3'd1;
    localparam logic [2:0] KIND_OUT_DUP   = 3'd2;
    localparam logic [2:0] KIND_OUT_TRUNC = 3'd3;
    localparam logic [2:0] KIND_OUT_APP   = 3'd4;

    typedef enum logic [4:0] {
        PH_WSP, PH_UDIG, PH_ULEAD, PH_UPLAIN, PH_QWORD, PH_BAR, PH_RSP, PH_RFD,
        PH_GT, PH_OPSP, PH_DUPSP, PH_DUPDIG, PH_NSTART, PH_UNAME, PH_QNAME,
        PH_OK, PH_ERR, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        EV_ACH, EV_AEND, EV_REDIR, EV_NCH, EV_NEND, EV_PIPE, EV_OK, EV_ERR
    } event_t;

    typedef struct packed {
        phase_t               phase;
        logic [7:0]           quote_char;
        logic                 escape_pending;
        logic [FD_BITS-1:0]   fd_acc;
        logic [FD_BITS-1:0]   src_acc;
        logic [2:0]           pending_kind;
        logic                 has_word;
    } tok_state_t;

    typedef struct packed {
        event_t               ev;
        logic [7:0]           char_value;
        logic [FD_BITS-1:0]   target_fd;
        logic [FD_BITS-1:0]   source_fd;
        logic [2:0]           redirect_kind;
    } tok_event_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]        cnt;
        tok_event_t [MAX_RES-1:0]   evt;
    } ev_batch_t;

    typedef struct packed {
        tok_state_t st;
        logic       emit;
        tok_event_t evt;
        logic       redo;
    } pass_res_t;

    localparam tok_state_t STATE_RESET = '{
        phase:          PH_WSP,
        quote_char:     8'd0,
        escape_pending: 1'b0,
        fd_acc:         '0,
        src_acc:        '0,
        pending_kind:   3'd0,
        has_word:       1'b0
    };

    function automatic logic is_space(logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c inside {CH_LT, CH_GT};
    endfunction

    function automatic logic is_quote(logic [7:0] c);
        return c inside {CH_DQUOTE, CH_SQUOTE};
    endfunction

    function automatic logic is_sep(logic [7:0] c);
        return c inside {CH_NUL, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_AMP, CH_BAR};
    endfunction

    function automatic logic [7:0] decode(logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_LC_N) r = CH_LF;
        else if (c == CH_LC_T) r = CH_TAB;
        return r;
    endfunction

    function automatic logic [FD_BITS-1:0] digit_val(logic [7:0] c);
        logic [7:0] d;
        d = c - CH_0;
        return {{(FD_BITS-4){1'b0}}, d[3:0]};
    endfunction

    // a * 10 + digit, saturating
    function automatic logic [FD_BITS-1:0] acc(logic [FD_BITS-1:0] a, logic [7:0] c);
        logic [FD_BITS+3:0] w;
        logic [FD_BITS+3:0] v;
        w = {4'd0, a};
        v = (w << 3) + (w << 1) + {4'd0, digit_val(c)};
        return (v > {4'd0, FD_MAX}) ? FD_MAX : v[FD_BITS-1:0];
    endfunction

    function automatic tok_event_t mk_event(event_t ev, logic [7:0] ch,
                                            logic [FD_BITS-1:0] tfd,
                                            logic [FD_BITS-1:0] sfd,
                                            logic [2:0] kind);
        tok_event_t e;
        e.ev            = ev;
        e.char_value    = ch;
        e.target_fd     = tfd;
        e.source_fd     = sfd;
        e.redirect_kind = kind;
        return e;
    endfunction

    function automatic tok_state_t start_op(tok_state_t s, logic [7:0] c,
                                            logic [FD_BITS-1:0] fd);
        tok_state_t r;
        r = s;
        r.fd_acc = fd;
        if (c == CH_LT) begin
            r.pending_kind = KIND_IN_FILE;
            r.phase        = PH_OPSP;
        end else begin
            r.pending_kind = KIND_OUT_TRUNC;
            r.phase        = PH_GT;
        end
        return r;
    endfunction

    function automatic logic [FD_BITS-1:0] def_fd(logic [7:0] c);
        return (c == CH_LT) ? FD_DEF_IN : FD_DEF_OUT;
    endfunction

    // one visit of the scanner to one byte
    function automatic pass_res_t pass_f(tok_state_t s, logic [7:0] c);
        pass_res_t r;
        event_t    chev;
        r.st   = s;
        r.emit = 1'b0;
        r.evt  = '0;
        r.redo = 1'b0;
        chev   = (s.phase == PH_QWORD) ? EV_ACH : EV_NCH;
        case (s.phase)
            PH_WSP:
            begin
                if (is_space(c)) begin
                end else if (is_quote(c)) begin
                    r.st.quote_char = c;
                    r.st.phase      = PH_QWORD;
                end else if (is_op(c)) begin
                    if (!s.has_word) r.st.phase = PH_ERR;
                    else r.st = start_op(s, c, def_fd(c));
                end else if (is_sep(c)) begin
                    if (!s.has_word) begin
                        r.st.phase = PH_ERR;
                    end else if (c == CH_BAR) begin
                        r.emit        = 1'b1;
                        r.evt         = mk_event(EV_PIPE, 8'd0, '0, '0, 3'd0);
                        r.st.has_word = 1'b0;
                        r.st.phase    = PH_BAR;
                    end else begin
                        r.st.phase = PH_OK;
                    end
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                    r.st.phase          = PH_UPLAIN;
                end else begin
                    r.emit = 1'b1;
                    r.evt  = mk_event(EV_ACH, c, '0, '0, 3'd0);
                    if (is_digit(c)) begin
                        r.st.fd_acc = digit_val(c);
                        r.st.phase  = PH_UDIG;
                    end else begin
                        r.st.phase = PH_UPLAIN;
                    end
                end
            end
            PH_UDIG, PH_ULEAD, PH_UPLAIN:
            begin
                if (s.escape_pending) begin
                    if (c == CH_NUL) begin
                        r.st.phase = PH_ERR;
                    end else begin
                        r.emit              = 1'b1;
                        r.evt               = mk_event(EV_ACH, decode(c), '0, '0, 3'd0);
                        r.st.escape_pending = 1'b0;
                    end
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                    if (s.phase == PH_UDIG) r.st.phase = PH_ULEAD;
                end else if (is_space(c) || is_sep(c)) begin
                    r.emit        = 1'b1;
                    r.evt         = mk_event(EV_AEND, 8'd0, '0, '0, 3'd0);
                    r.st.has_word = 1'b1;
                    r.st.phase    = PH_WSP;
                    r.redo        = !is_space(c);
                end else if (is_op(c)) begin
                    if (!s.has_word || s.phase == PH_ULEAD) r.st.phase = PH_ERR;
                    else if (s.phase == PH_UDIG) r.st = start_op(s, c, s.fd_acc);
                    else r.st.phase = PH_OK;
                end else begin
                    r.emit = 1'b1;
                    r.evt  = mk_event(EV_ACH, c, '0, '0, 3'd0);
                    if (s.phase == PH_UDIG) begin
                        if (is_digit(c)) r.st.fd_acc = acc(s.fd_acc, c);
                        else r.st.phase = PH_ULEAD;
                    end
                end
            end
            PH_QWORD, PH_QNAME:
            begin
                if (s.escape_pending) begin
                    if (c == CH_NUL) begin
                        r.st.phase = PH_ERR;
                    end else begin
                        r.emit              = 1'b1;
                        r.evt               = mk_event(chev, decode(c), '0, '0, 3'd0);
                        r.st.escape_pending = 1'b0;
                    end
                end else if (c == s.quote_char) begin
                    r.emit = 1'b1;
                    if (s.phase == PH_QWORD) begin
                        r.evt         = mk_event(EV_AEND, 8'd0, '0, '0, 3'd0);
                        r.st.has_word = 1'b1;
                        r.st.phase    = PH_WSP;
                    end else begin
                        r.evt      = mk_event(EV_NEND, 8'd0, s.fd_acc, '0, s.pending_kind);
                        r.st.phase = PH_RSP;
                    end
                end else if (c == CH_NUL) begin
                    r.st.phase = PH_ERR;
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                end else begin
                    r.emit = 1'b1;
                    r.evt  = mk_event(chev, c, '0, '0, 3'd0);
                end
            end
            PH_BAR:
            begin
                if (c == CH_BAR) begin
                    r.st.phase = PH_OK;
                end else begin
                    r.st.phase = PH_WSP;
                    r.redo     = 1'b1;
                end
            end
            PH_RSP:
            begin
                if (is_space(c)) begin
                end else if (is_op(c)) begin
                    r.st = start_op(s, c, def_fd(c));
                end else if (is_digit(c)) begin
                    r.st.fd_acc = digit_val(c);
                    r.st.phase  = PH_RFD;
                end else if (c == CH_BAR) begin
                    r.emit        = 1'b1;
                    r.evt         = mk_event(EV_PIPE, 8'd0, '0, '0, 3'd0);
                    r.st.has_word = 1'b0;
                    r.st.phase    = PH_BAR;
                end else begin
                    r.st.phase = PH_OK;
                end
            end
            PH_RFD:
            begin
                if (is_digit(c)) r.st.fd_acc = acc(s.fd_acc, c);
                else if (is_op(c)) r.st = start_op(s, c, s.fd_acc);
                else r.st.phase = PH_ERR;
            end
            PH_GT:
            begin
                if (c == CH_GT) begin
                    r.st.pending_kind = KIND_OUT_APP;
                    r.st.phase        = PH_NSTART;
                end else begin
                    r.st.phase = PH_OPSP;
                    r.redo     = 1'b1;
                end
            end
            PH_OPSP:
            begin
                if (is_space(c)) begin
                end else if (c == CH_AMP) begin
                    r.st.pending_kind = s.pending_kind - 3'd1;
                    r.st.src_acc      = '0;
                    r.st.phase        = PH_DUPSP;
                end else begin
                    r.st.phase = PH_NSTART;
                    r.redo     = 1'b1;
                end
            end
            PH_DUPSP:
            begin
                if (is_space(c)) begin
                end else if (is_digit(c)) begin
                    r.st.src_acc = digit_val(c);
                    r.st.phase   = PH_DUPDIG;
                end else begin
                    r.st.phase = PH_ERR;
                end
            end
            PH_DUPDIG:
            begin
                if (is_digit(c)) begin
                    r.st.src_acc = acc(s.src_acc, c);
                end else begin
                    r.emit     = 1'b1;
                    r.evt      = mk_event(EV_REDIR, 8'd0, s.fd_acc, s.src_acc,
                                          s.pending_kind);
                    r.st.phase = PH_RSP;
                    r.redo     = 1'b1;
                end
            end
            PH_NSTART:
            begin
                if (is_space(c)) begin
                end else if (is_quote(c)) begin
                    r.st.quote_char = c;
                    r.st.phase      = PH_QNAME;
                end else if (is_sep(c) || is_op(c)) begin
                    r.st.phase = PH_ERR;
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                    r.st.phase          = PH_UNAME;
                end else begin
                    r.emit     = 1'b1;
                    r.evt      = mk_event(EV_NCH, c, '0, '0, 3'd0);
                    r.st.phase = PH_UNAME;
                end
            end
            PH_UNAME:
            begin
                if (s.escape_pending) begin
                    if (c == CH_NUL) begin
                        r.st.phase = PH_ERR;
                    end else begin
                        r.emit              = 1'b1;
                        r.evt               = mk_event(EV_NCH, decode(c), '0, '0, 3'd0);
                        r.st.escape_pending = 1'b0;
                    end
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                end else if (is_space(c) || is_sep(c)) begin
                    r.emit     = 1'b1;
                    r.evt      = mk_event(EV_NEND, 8'd0, s.fd_acc, '0, s.pending_kind);
                    r.st.phase = PH_RSP;
                    r.redo     = !is_space(c);
                end else if (is_op(c)) begin
                    r.st.phase = PH_ERR;
                end else begin
                    r.emit = 1'b1;
                    r.evt  = mk_event(EV_NCH, c, '0, '0, 3'd0);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // add one event unless the batch is full
    function automatic ev_batch_t append(ev_batch_t b, tok_event_t e);
        ev_batch_t r;
        r = b;
        for (int i = 0; i < MAX_RES; i++) begin
            if (b.cnt == CNT_BITS'(i)) r.evt[i] = e;
        end
        if (b.cnt < CNT_BITS'(MAX_RES)) r.cnt = b.cnt + CNT_BITS'(1);
        return r;
    endfunction

endpackage

@@ sv/shell_command_line_tokenizer.sv @@
// Command line tokenizer: takes one byte per transfer on s_axis (tlast marks the last byte
// of the line, a zero byte ends it early) and emits token events on m_axis, one event per
// transfer, with tlast on the final event caused by a byte. A byte enters an input register,
// is scanned combinationally and its events (up to three) land in a result buffer that drains
// one event per cycle while m_axis is ready; the next byte is taken in the same cycle that the
// buffer's last event leaves. Events are emitted before the line is validated, so a consumer
// discards everything up to an error event.
module shell_command_line_tokenizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // byte_in
    input  logic                                s_axis_tlast,   // end_of_line
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // char_value, target_fd, source_fd, redirect_kind, zero pad
    output logic [sclt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [2:0]                          m_axis_tuser,   // event_res
    output logic                                m_axis_tlast    // last_of_run
);
    import sclt_pkg::*;

    logic       free;
    logic       load;
    ev_batch_t  batch;
    tok_event_t m_evt;

    sclt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_byte  (s_axis_tdata),
        .s_eol   (s_axis_tlast),
        .free    (free),
        .load    (load),
        .batch   (batch)
    );

    sclt_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .batch   (batch),
        .free    (free),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_evt   (m_evt),
        .m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, m_evt.redirect_kind, m_evt.source_fd,
                           m_evt.target_fd, m_evt.char_value};
    assign m_axis_tuser = m_evt.ev;

endmodule

@@ sv/sclt_feed.sv @@
module sclt_feed (
    input  sclt_pkg::tok_state_t st_in,
    input  logic [7:0]           c,
    output sclt_pkg::tok_state_t st_out,
    output sclt_pkg::ev_batch_t  batch
);
    import sclt_pkg::*;

    pass_res_t p1;
    pass_res_t p2;
    pass_res_t p3;

    // a byte may be revisited after a phase change, at most three visits
    always_comb
    begin
        ev_batch_t b;
        b     = '0;
        p1    = pass_f(st_in, c);
        p2    = pass_f(p1.st, c);
        p3    = pass_f(p2.st, c);
        if (p1.emit) b = append(b, p1.evt);
        if (p1.redo && p2.emit) b = append(b, p2.evt);
        if (p1.redo && p2.redo && p3.emit) b = append(b, p3.evt);
        if (!p1.redo) st_out = p1.st;
        else if (!p2.redo) st_out = p2.st;
        else st_out = p3.st;
        batch = b;
    end

endmodule

@@ sv/sclt_core.sv @@
`include "shell_command_line_tokenizer_defines.svh"

module sclt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte,
    input  logic                s_eol,
    input  logic                free,
    output logic                load,
    output sclt_pkg::ev_batch_t batch
);
    import sclt_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       eol_reg;
    tok_state_t state_reg;
    tok_state_t state_next;

    tok_state_t state_a;
    tok_state_t state_b;
    ev_batch_t  batch_a;
    ev_batch_t  batch_b;

    assign load          = in_valid_reg && free;
    assign s_ready       = !in_valid_reg || load;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (load) state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte;
            eol_reg  <= s_eol;
        end
    end

    // the byte itself
    sclt_feed u_feed_byte (
        .st_in  (state_reg),
        .c      (byte_reg),
        .st_out (state_a),
        .batch  (batch_a)
    );

    // implied terminator at end of line
    sclt_feed u_feed_end (
        .st_in  (state_a),
        .c      (CH_NUL),
        .st_out (state_b),
        .batch  (batch_b)
    );

    always_comb
    begin
        ev_batch_t  nb;
        tok_state_t s_line;
        logic       use_end;
        logic       line_ends;
        nb         = '0;
        s_line     = state_a;
        state_next = state_reg;
        use_end    = (byte_reg != CH_NUL) && eol_reg;
        line_ends  = (byte_reg == CH_NUL) || eol_reg;
        if (state_reg.phase == PH_DONE) begin
            if (eol_reg) state_next = STATE_RESET;
        end else begin
            nb = batch_a;
            if (use_end) begin
                s_line = state_b;
                for (int i = 0; i < MAX_RES; i++) begin
                    if (CNT_BITS'(i) < batch_b.cnt) nb = append(nb, batch_b.evt[i]);
                end
            end
            if (line_ends) begin
                nb = append(nb, mk_event((s_line.phase == PH_OK) ? EV_OK : EV_ERR,
                                         8'd0, '0, '0, 3'd0));
                if (eol_reg) begin
                    state_next = STATE_RESET;
                end else begin
                    state_next       = s_line;
                    state_next.phase = PH_DONE;
                end
            end else begin
                state_next = s_line;
            end
        end
        batch = nb;
    end

    `SCLT_ASSERT_IMP(a_done_silent, in_valid_reg && state_reg.phase == PH_DONE,
                     batch.cnt == '0, "bytes after a zero byte produced events")
    `SCLT_ASSERT_NXT(a_eol_resets, load && eol_reg,
                     state_reg.phase == PH_WSP && !state_reg.has_word,
                     "scanner not back to line start after end of line")

endmodule

@@ sv/sclt_resq.sv @@
`include "shell_command_line_tokenizer_defines.svh"

module sclt_resq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sclt_pkg::ev_batch_t  batch,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sclt_pkg::tok_event_t m_evt,
    output logic                 m_last
);
    import sclt_pkg::*;

    tok_event_t [MAX_RES-1:0] evt_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      rd_reg;
    logic [CNT_BITS-1:0]      rd_next;
    logic                     out_xfer;

    assign m_valid  = rd_reg < cnt_reg;
    assign out_xfer = m_valid && m_ready;
    assign rd_next  = rd_reg + CNT_BITS'(1);
    assign m_last   = rd_next == cnt_reg;
    // next batch may enter as the last event of this one leaves
    assign free     = !m_valid || (out_xfer && m_last);

    always_comb
    begin
        m_evt = evt_reg[0];
        for (int i = 0; i < MAX_RES; i++) begin
            if (rd_reg == CNT_BITS'(i)) m_evt = evt_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= batch.cnt;
            rd_reg  <= '0;
        end else if (out_xfer) begin
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) evt_reg <= batch.evt;
    end

    `SCLT_ASSERT_IMP(a_rd_le_cnt, 1'b1, rd_reg <= cnt_reg,
                     "read pointer past event count")
    `SCLT_ASSERT_NXT(a_load_shows, load && batch.cnt != '0, m_valid,
                     "loaded events not offered")
    `SCLT_ASSERT_IMP(a_load_when_drained, load, !m_valid || (m_ready && m_last),
                     "batch loaded over undelivered events")

endmodule

@@ test/shell_command_line_tokenizer_checker.sv @@
module shell_command_line_tokenizer_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [sclt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic [2:0]                          m_axis_tuser,
    input  logic                                m_axis_tlast,
    output int                                  mismatches,
    output int                                  outstanding
);
    import sclt_pkg::*;

    typedef struct packed {
        event_t             ev;
        logic [7:0]         ch;
        logic [FD_BITS-1:0] tfd;
        logic [FD_BITS-1:0] sfd;
        logic [2:0]         kind;
        logic               last;
    } token_rec_t;

    phase_t             scan_phase;
    logic [7:0]         open_quote;
    logic               escaped;
    logic [FD_BITS-1:0] fd_digits;
    logic [FD_BITS-1:0] src_digits;
    logic [2:0]         redir_kind;
    logic               cmd_has_word;

    token_rec_t step_events[$];
    token_rec_t pending_tokens[$];
    int         fail_count = 0;
    int         waiting    = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_redir_op(logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI)
            || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        if (c == CH_LC_N) return CH_LF;
        if (c == CH_LC_T) return CH_TAB;
        return c;
    endfunction

    function automatic logic [FD_BITS-1:0] digit_of(logic [7:0] c);
        return FD_BITS'(c - CH_0);
    endfunction

    // decimal shift-in, clamped to the largest descriptor
    function automatic logic [FD_BITS-1:0] sat_acc(logic [FD_BITS-1:0] a, logic [7:0] c);
        int v;
        v = int'(a) * 10 + int'(c) - int'(CH_0);
        return (v > int'(FD_MAX)) ? FD_MAX : FD_BITS'(v);
    endfunction

    function automatic void clear_scan();
        scan_phase   = PH_WSP;
        open_quote   = 8'd0;
        escaped      = 1'b0;
        fd_digits    = '0;
        src_digits   = '0;
        redir_kind   = 3'd0;
        cmd_has_word = 1'b0;
    endfunction

    function automatic void add_event(event_t ev, logic [7:0] ch, logic [FD_BITS-1:0] tfd,
                                      logic [FD_BITS-1:0] sfd, logic [2:0] kind);
        token_rec_t r;
        r.ev   = ev;
        r.ch   = ch;
        r.tfd  = tfd;
        r.sfd  = sfd;
        r.kind = kind;
        r.last = 1'b0;
        if (step_events.size() < MAX_RES) step_events.push_back(r);
    endfunction

    function automatic void open_redir(logic [7:0] c, logic [FD_BITS-1:0] fd);
        fd_digits = fd;
        if (c == CH_LT)
        begin
            redir_kind = KIND_IN_FILE;
            scan_phase = PH_OPSP;
        end
        else
        begin
            redir_kind = KIND_OUT_TRUNC;
            scan_phase = PH_GT;
        end
    endfunction

    function automatic void start_pipe();
        add_event(EV_PIPE, 8'd0, '0, '0, 3'd0);
        cmd_has_word = 1'b0;
        scan_phase   = PH_BAR;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic   again;
        event_t char_ev;
        again = 1'b1;
        while (again)
        begin
            again   = 1'b0;
            char_ev = (scan_phase == PH_QWORD) ? EV_ACH : EV_NCH;
            case (scan_phase)
                PH_WSP:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_DQUOTE || c == CH_SQUOTE)
                    begin
                        open_quote = c;
                        scan_phase = PH_QWORD;
                    end
                    else if (is_redir_op(c))
                    begin
                        if (!cmd_has_word) scan_phase = PH_ERR;
                        else open_redir(c, (c == CH_LT) ? FD_DEF_IN : FD_DEF_OUT);
                    end
                    else if (is_delim(c))
                    begin
                        if (!cmd_has_word) scan_phase = PH_ERR;
                        else if (c == CH_BAR) start_pipe();
                        else scan_phase = PH_OK;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escaped    = 1'b1;
                        scan_phase = PH_UPLAIN;
                    end
                    else
                    begin
                        add_event(EV_ACH, c, '0, '0, 3'd0);
                        if (is_num(c))
                        begin
                            fd_digits  = digit_of(c);
                            scan_phase = PH_UDIG;
                        end
                        else
                        begin
                            scan_phase = PH_UPLAIN;
                        end
                    end
                end
                PH_UDIG, PH_ULEAD, PH_UPLAIN:
                begin
                    if (escaped)
                    begin
                        if (c == CH_NUL)
                        begin
                            scan_phase = PH_ERR;
                        end
                        else
                        begin
                            add_event(EV_ACH, unescape(c), '0, '0, 3'd0);
                            escaped = 1'b0;
                        end
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escaped = 1'b1;
                        if (scan_phase == PH_UDIG) scan_phase = PH_ULEAD;
                    end
                    else if (is_blank(c) || is_delim(c))
                    begin
                        add_event(EV_AEND, 8'd0, '0, '0, 3'd0);
                        cmd_has_word = 1'b1;
                        scan_phase   = PH_WSP;
                        again        = !is_blank(c);
                    end
                    else if (is_redir_op(c))
                    begin
                        // a word glued to < or > is only tentative
                        if (!cmd_has_word || scan_phase == PH_ULEAD) scan_phase = PH_ERR;
                        else if (scan_phase == PH_UDIG) open_redir(c, fd_digits);
                        else scan_phase = PH_OK;
                    end
                    else
                    begin
                        add_event(EV_ACH, c, '0, '0, 3'd0);
                        if (scan_phase == PH_UDIG)
                        begin
                            if (is_num(c)) fd_digits = sat_acc(fd_digits, c);
                            else scan_phase = PH_ULEAD;
                        end
                    end
                end
                PH_QWORD, PH_QNAME:
                begin
                    if (escaped)
                    begin
                        if (c == CH_NUL)
                        begin
                            scan_phase = PH_ERR;
                        end
                        else
                        begin
                            add_event(char_ev, unescape(c), '0, '0, 3'd0);
                            escaped = 1'b0;
                        end
                    end
                    else if (c == open_quote)
                    begin
                        if (scan_phase == PH_QWORD)
                        begin
                            add_event(EV_AEND, 8'd0, '0, '0, 3'd0);
                            cmd_has_word = 1'b1;
                            scan_phase   = PH_WSP;
                        end
                        else
                        begin
                            add_event(EV_NEND, 8'd0, fd_digits, '0, redir_kind);
                            scan_phase = PH_RSP;
                        end
                    end
                    else if (c == CH_NUL)
                    begin
                        scan_phase = PH_ERR;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escaped = 1'b1;
                    end
                    else
                    begin
                        add_event(char_ev, c, '0, '0, 3'd0);
                    end
                end
                PH_BAR:
                begin
                    // a second bar closes the line cleanly
                    if (c == CH_BAR)
                    begin
                        scan_phase = PH_OK;
                    end
                    else
                    begin
                        scan_phase = PH_WSP;
                        again      = 1'b1;
                    end
                end
                PH_RSP:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (is_redir_op(c))
                    begin
                        open_redir(c, (c == CH_LT) ? FD_DEF_IN : FD_DEF_OUT);
                    end
                    else if (is_num(c))
                    begin
                        fd_digits  = digit_of(c);
                        scan_phase = PH_RFD;
                    end
                    else if (c == CH_BAR)
                    begin
                        start_pipe();
                    end
                    else
                    begin
                        scan_phase = PH_OK;
                    end
                end
                PH_RFD:
                begin
                    if (is_num(c)) fd_digits = sat_acc(fd_digits, c);
                    else if (is_redir_op(c)) open_redir(c, fd_digits);
                    else scan_phase = PH_ERR;
                end
                PH_GT:
                begin
                    if (c == CH_GT)
                    begin
                        redir_kind = KIND_OUT_APP;
                        scan_phase = PH_NSTART;
                    end
                    else
                    begin
                        scan_phase = PH_OPSP;
                        again      = 1'b1;
                    end
                end
                PH_OPSP:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_AMP)
                    begin
                        redir_kind = redir_kind - 3'd1;
                        src_digits = '0;
                        scan_phase = PH_DUPSP;
                    end
                    else
                    begin
                        scan_phase = PH_NSTART;
                        again      = 1'b1;
                    end
                end
                PH_DUPSP:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (is_num(c))
                    begin
                        src_digits = digit_of(c);
                        scan_phase = PH_DUPDIG;
                    end
                    else
                    begin
                        scan_phase = PH_ERR;
                    end
                end
                PH_DUPDIG:
                begin
                    if (is_num(c))
                    begin
                        src_digits = sat_acc(src_digits, c);
                    end
                    else
                    begin
                        add_event(EV_REDIR, 8'd0, fd_digits, src_digits, redir_kind);
                        scan_phase = PH_RSP;
                        again      = 1'b1;
                    end
                end
                PH_NSTART:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_DQUOTE || c == CH_SQUOTE)
                    begin
                        open_quote = c;
                        scan_phase = PH_QNAME;
                    end
                    else if (is_delim(c) || is_redir_op(c))
                    begin
                        scan_phase = PH_ERR;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escaped    = 1'b1;
                        scan_phase = PH_UNAME;
                    end
                    else
                    begin
                        add_event(EV_NCH, c, '0, '0, 3'd0);
                        scan_phase = PH_UNAME;
                    end
                end
                PH_UNAME:
                begin
                    if (escaped)
                    begin
                        if (c == CH_NUL)
                        begin
                            scan_phase = PH_ERR;
                        end
                        else
                        begin
                            add_event(EV_NCH, unescape(c), '0, '0, 3'd0);
                            escaped = 1'b0;
                        end
                    end
                    else if (c == CH_BSLASH)
                    begin
                        escaped = 1'b1;
                    end
                    else if (is_blank(c) || is_delim(c))
                    begin
                        add_event(EV_NEND, 8'd0, fd_digits, '0, redir_kind);
                        scan_phase = PH_RSP;
                        again      = !is_blank(c);
                    end
                    else if (is_redir_op(c))
                    begin
                        scan_phase = PH_ERR;
                    end
                    else
                    begin
                        add_event(EV_NCH, c, '0, '0, 3'd0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eol);
        step_events.delete();
        if (scan_phase == PH_DONE)
        begin
            // rest of a line cut short by a zero byte
            if (eol) clear_scan();
        end
        else
        begin
            scan_char(c);
            if (c != CH_NUL && eol) scan_char(CH_NUL);
            if (c == CH_NUL || eol)
            begin
                add_event((scan_phase == PH_OK) ? EV_OK : EV_ERR, 8'd0, '0, '0, 3'd0);
                if (eol) clear_scan();
                else scan_phase = PH_DONE;
            end
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) pending_tokens.push_back(step_events[i]);
    endfunction

    task automatic report(input string msg);
        fail_count++;
        // keep the log short on a badly broken design
        if (fail_count <= 200) $display("ERROR: %s", msg);
    endtask

    task automatic check_transfer();
        token_rec_t want;
        if (pending_tokens.size() == 0)
        begin
            report($sformatf("event %0d with nothing outstanding", m_axis_tuser));
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (m_axis_tuser !== want.ev)
                report($sformatf("event: got %0d want %0d", m_axis_tuser, want.ev));
            if (m_axis_tdata[7:0] !== want.ch)
                report($sformatf("char_value: got %0h want %0h", m_axis_tdata[7:0], want.ch));
            if (m_axis_tdata[8 +: FD_BITS] !== want.tfd)
                report($sformatf("target_fd: got %0d want %0d",
                                 m_axis_tdata[8 +: FD_BITS], want.tfd));
            if (m_axis_tdata[8 + FD_BITS +: FD_BITS] !== want.sfd)
                report($sformatf("source_fd: got %0d want %0d",
                                 m_axis_tdata[8 + FD_BITS +: FD_BITS], want.sfd));
            if (m_axis_tdata[8 + 2 * FD_BITS +: 3] !== want.kind)
                report($sformatf("redirect_kind: got %0d want %0d",
                                 m_axis_tdata[8 + 2 * FD_BITS +: 3], want.kind));
            if (m_axis_tlast !== want.last)
                report($sformatf("last_of_run: got %0b want %0b", m_axis_tlast, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            pending_tokens.delete();
            waiting = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) check_transfer();
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
            waiting = pending_tokens.size();
        end
    end

endmodule

@@ test/shell_command_line_tokenizer_tb.sv @@
module shell_command_line_tokenizer_tb;
    import sclt_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_BYTES  = 85;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] SPECIALS [12] = '{CH_LT, CH_GT, CH_BAR, CH_AMP, CH_SEMI, CH_DQUOTE,
                                             CH_SQUOTE, CH_BSLASH, CH_NUL, CH_SPACE, CH_0,
                                             CH_LPAREN};
    localparam logic [7:0] PUNCT [6]     = '{8'h2d, 8'h2e, 8'h2f, 8'h3d, 8'h7e, 8'h2a};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;    // byte_in
    logic                   s_axis_tlast = 1'b0;    // end_of_line
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // char_value, target_fd, source_fd, kind
    logic [2:0]             m_axis_tuser;           // event_res
    logic                   m_axis_tlast;           // last_of_run

    int         mismatches;
    int         outstanding;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         cycle_cnt = 0;
    logic [7:0] line_buf[$];

    shell_command_line_tokenizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    shell_command_line_tokenizer_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("shell_command_line_tokenizer verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] plain_char();
        int r;
        r = $urandom_range(19);
        if (r < 9) return CH_LC_A + 8'($urandom_range(25));
        if (r < 14) return CH_0 + 8'($urandom_range(9));
        if (r < 17) return 8'($urandom_range(128, 255));
        if (r < 19) return PUNCT[$urandom_range(5)];
        return $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(14, 31));
    endfunction

    function automatic void add_escape();
        int r;
        r = $urandom_range(3);
        line_buf.push_back(CH_BSLASH);
        case (r)
            0:       line_buf.push_back(CH_LC_N);
            1:       line_buf.push_back(CH_LC_T);
            2:       line_buf.push_back(CH_BSLASH);
            default: line_buf.push_back(8'($urandom_range(1, 255)));
        endcase
    endfunction

    function automatic void add_blanks(int lo, int hi);
        repeat ($urandom_range(lo, hi))
        begin
            if ($urandom_range(9) < 7) line_buf.push_back(CH_SPACE);
            else line_buf.push_back(8'($urandom_range(CH_TAB, CH_CR)));
        end
    endfunction

    function automatic void add_digits();
        int n;
        // now and then long enough to saturate
        n = ($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 2);
        repeat (n) line_buf.push_back(CH_0 + 8'($urandom_range(9)));
    endfunction

    function automatic void add_word();
        logic [7:0] q;
        logic [7:0] b;
        if ($urandom_range(3) == 0)
        begin
            q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
            line_buf.push_back(q);
            repeat ($urandom_range(0, 4))
            begin
                if ($urandom_range(4) == 0)
                begin
                    add_escape();
                end
                else
                begin
                    do b = 8'($urandom_range(1, 255)); while (b == q || b == CH_BSLASH);
                    line_buf.push_back(b);
                end
            end
            line_buf.push_back(q);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(5) == 0) add_escape();
                else line_buf.push_back(plain_char());
            end
        end
    endfunction

    function automatic void add_redir();
        int op;
        op = $urandom_range(2);
        if ($urandom_range(9) < 8) add_blanks(1, 2);
        if ($urandom_range(9) < 4) add_digits();
        line_buf.push_back((op == 0) ? CH_LT : CH_GT);
        if (op == 2) line_buf.push_back(CH_GT);
        add_blanks(0, 1);
        if (op != 2 && $urandom_range(9) < 4)
        begin
            line_buf.push_back(CH_AMP);
            add_blanks(0, 1);
            add_digits();
        end
        else
        begin
            add_word();
        end
    endfunction

    function automatic void add_command();
        add_word();
        repeat ($urandom_range(0, 2))
        begin
            add_blanks(1, 2);
            add_word();
        end
        repeat ($urandom_range(0, 2)) add_redir();
    endfunction

    function automatic void add_junk();
        repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_line();
        int pos;
        line_buf.delete();
        if ($urandom_range(19) == 0)
        begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            add_blanks(0, 1);
            add_command();
            repeat ($urandom_range(0, 2))
            begin
                add_blanks(0, 1);
                line_buf.push_back(CH_BAR);
                add_blanks(0, 1);
                add_command();
            end
            add_blanks(0, 1);
            case ($urandom_range(9))
                0:
                begin
                    line_buf.push_back(SPECIALS[$urandom_range(1) ? 4 : 11]);
                    add_junk();
                end
                1:
                begin
                    line_buf.push_back(CH_BAR);
                    line_buf.push_back(CH_BAR);
                    add_junk();
                end
                2:
                begin
                    line_buf.push_back(CH_NUL);
                    add_junk();
                end
                default:
                begin
                end
            endcase
            // broken lines
            if ($urandom_range(4) == 0)
            begin
                pos = $urandom_range(line_buf.size() - 1);
                case ($urandom_range(2))
                    0:       line_buf[pos] = 8'($urandom_range(255));
                    1:       line_buf.insert(pos, SPECIALS[$urandom_range(11)]);
                    default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
                endcase
            end
        end
        if (line_buf.size() == 0) line_buf.push_back(plain_char());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eol);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
        send_line();
    endtask

    initial
    begin
        int sent;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("a 2>&1");
        send_text("||");
        send_text("b||c");
        send_text("'q\\");
        send_text("c>>'f'");
        line_buf = '{8'hff, CH_NUL, CH_LC_A + 8'd25};
        send_line();
        line_buf = '{CH_NUL};
        send_line();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_line();
                send_line();
                sent += line_buf.size();
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        wait (outstanding == 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("shell_command_line_tokenizer verification clean");
        else
            $display("shell_command_line_tokenizer verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sclt_pkg.sv
sv/sclt_feed.sv
sv/sclt_core.sv
sv/sclt_resq.sv
sv/shell_command_line_tokenizer.sv
test/shell_command_line_tokenizer_checker.sv
test/shell_command_line_tokenizer_tb.sv
